### rtl/polymul_pkg.sv
// shared constants, types and helpers of the polynomial multiplier
package polymul_pkg;

    localparam int MAX_DEGREE = 31;
    localparam int DEG_W      = 5;
    localparam int IDX_W      = 6;
    localparam int COEF_W     = 32;
    localparam int RAM_DEPTH  = MAX_DEGREE + 1;
    localparam int ADDR_W     = $clog2(RAM_DEPTH);

    localparam logic [1:0] REQ_LOAD_A = 2'd0;
    localparam logic [1:0] REQ_LOAD_B = 2'd1;
    localparam logic [1:0] REQ_START  = 2'd2;

    localparam int PADDR_W = 3;

    typedef struct packed {
        logic [1:0]               req_type;
        logic [DEG_W-1:0]         coef_index;
        logic signed [COEF_W-1:0] coef_value;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]         product_index;
        logic signed [COEF_W-1:0] product_coef;
        logic                     last;
    } t_out_item;

    typedef struct packed {
        logic             valid;
        logic             row_end;
        logic             top_row;
        logic [IDX_W-1:0] k;
    } t_issue;

    function automatic logic [DEG_W-1:0] clamp_degree(input logic [DEG_W-1:0] d);
        logic [DEG_W-1:0] r;
        if (int'(d) > MAX_DEGREE) begin
            r = DEG_W'(MAX_DEGREE);
        end else begin
            r = d;
        end
        return r;
    endfunction

endpackage

### rtl/polymul_ram.sv
// simple dual-port coefficient memory with registered read
module polymul_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/polymul_seq.sv
// sequencer walking product rows and coefficient pairs
module polymul_seq import polymul_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DEG_W-1:0]  i_degree_a,
    input  logic [DEG_W-1:0]  i_degree_b,
    input  logic              i_out_busy,
    input  logic              i_row_done,
    output logic              o_idle,
    output logic [ADDR_W-1:0] o_addr_a,
    output logic [ADDR_W-1:0] o_addr_b,
    output t_issue            o_issue
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WAIT  = 2'd1;
    localparam logic [1:0] S_ISSUE = 2'd2;
    localparam logic [1:0] S_DRAIN = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [IDX_W-1:0]  r_k, n_k;
    logic [IDX_W-1:0]  r_top, n_top;
    logic [ADDR_W-1:0] r_i, n_i;
    logic [ADDR_W-1:0] r_hi, n_hi;

    logic [DEG_W-1:0]  w_da, w_db;
    logic [IDX_W-1:0]  w_lo_full, w_diff;
    logic [ADDR_W-1:0] w_lo, w_hi;
    logic              w_row_end;

    assign w_da      = clamp_degree(i_degree_a);
    assign w_db      = clamp_degree(i_degree_b);
    assign w_lo_full = r_k - {1'b0, w_db};
    assign w_lo      = (r_k > {1'b0, w_db}) ? w_lo_full[ADDR_W-1:0] : '0;
    assign w_hi      = (r_k < {1'b0, w_da}) ? r_k[ADDR_W-1:0] : w_da;
    assign w_diff    = r_k - {1'b0, r_i};
    assign w_row_end = (r_i == r_hi);

    assign o_idle   = (r_state == S_IDLE);
    assign o_addr_a = r_i;
    assign o_addr_b = w_diff[ADDR_W-1:0];

    always_comb begin
        o_issue         = '0;
        o_issue.valid   = (r_state == S_ISSUE);
        o_issue.row_end = w_row_end;
        o_issue.top_row = (r_k == r_top);
        o_issue.k       = r_k;
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_top   = r_top;
        n_i     = r_i;
        n_hi    = r_hi;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_top   = IDX_W'({1'b0, w_da} + {1'b0, w_db});
                    n_k     = '0;
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (!i_out_busy) begin
                    n_i     = w_lo;
                    n_hi    = w_hi;
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (w_row_end) begin
                    n_state = S_DRAIN;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_DRAIN: begin
                if (i_row_done) begin
                    if (r_k == r_top) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_WAIT;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_k   <= n_k;
        r_top <= n_top;
        r_i   <= n_i;
        r_hi  <= n_hi;
    end

endmodule

### rtl/polymul_mac.sv
// multiply-accumulate pipeline and output register
module polymul_mac import polymul_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_issue            i_issue,
    input  logic [COEF_W-1:0] i_coef_a,
    input  logic [COEF_W-1:0] i_coef_b,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output t_out_item         o_out_data,
    output logic              o_row_done
);

    t_issue            r_s1, r_s2;
    logic [COEF_W-1:0] r_prod;
    logic [COEF_W-1:0] r_acc;
    logic              r_out_valid;
    t_out_item         r_out_data;
    logic [COEF_W-1:0] w_prod, w_sum;

    assign w_prod     = COEF_W'(i_coef_a * i_coef_b);
    assign w_sum      = r_acc + r_prod;
    assign o_row_done = r_s2.valid && r_s2.row_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1        <= '0;
            r_s2        <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1 <= i_issue;
            r_s2 <= r_s1;
            if (r_s2.valid) begin
                r_acc <= r_s2.row_end ? '0 : w_sum;
            end
            if (o_row_done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_prod <= w_prod;
        if (o_row_done) begin
            r_out_data.product_index <= r_s2.k;
            r_out_data.product_coef  <= w_sum;
            r_out_data.last          <= r_s2.top_row;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### rtl/polynomial_multiplier.sv
// top level of the polynomial multiplier
//
//  channel   direction  handshake               payload
//  in        in         i_in_valid/o_in_ready   i_in_data (t_in_item)
//  out       out        o_out_valid/i_out_ready o_out_data (t_out_item)
//  cfg       in         psel/penable/pready     paddr, pwdata, prdata
//
// a load transfer writes one coefficient memory
// a start transfer is paced by output stalls and by the single multiply-accumulate
// and the one read port of each memory
// each product row waits until the output register is free before it begins
// o_in_ready stays low until the last coefficient is in the output register
// reset clears the control state and both degree registers; memories are not cleared
module polynomial_multiplier import polymul_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [DEG_W-1:0]  r_degree_a, r_degree_b;
    logic              w_cfg_wr, w_in_xfer, w_start, w_we_a, w_we_b, w_idx_ok;
    logic              w_idle, w_row_done;
    logic [ADDR_W-1:0] w_addr_a, w_addr_b;
    logic [COEF_W-1:0] w_coef_a, w_coef_b;
    t_issue            w_issue;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = paddr[2] ? {{(32-DEG_W){1'b0}}, r_degree_b}
                               : {{(32-DEG_W){1'b0}}, r_degree_a};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree_a <= '0;
            r_degree_b <= '0;
        end else if (w_cfg_wr) begin
            if (paddr[2]) begin
                r_degree_b <= pwdata[DEG_W-1:0];
            end else begin
                r_degree_a <= pwdata[DEG_W-1:0];
            end
        end
    end

    assign o_in_ready = w_idle;
    assign w_in_xfer  = i_in_valid && w_idle;
    assign w_idx_ok   = (int'(i_in_data.coef_index) <= MAX_DEGREE);
    assign w_we_a     = w_in_xfer && w_idx_ok && (i_in_data.req_type == REQ_LOAD_A);
    assign w_we_b     = w_in_xfer && w_idx_ok && (i_in_data.req_type == REQ_LOAD_B);
    assign w_start    = w_in_xfer && (i_in_data.req_type == REQ_START);

    polymul_ram #(.DEPTH(RAM_DEPTH), .WIDTH(COEF_W)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (i_in_data.coef_index[ADDR_W-1:0]),
        .i_wdata (i_in_data.coef_value),
        .i_raddr (w_addr_a),
        .o_rdata (w_coef_a)
    );

    polymul_ram #(.DEPTH(RAM_DEPTH), .WIDTH(COEF_W)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (i_in_data.coef_index[ADDR_W-1:0]),
        .i_wdata (i_in_data.coef_value),
        .i_raddr (w_addr_b),
        .o_rdata (w_coef_b)
    );

    polymul_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_degree_a (r_degree_a),
        .i_degree_b (r_degree_b),
        .i_out_busy (o_out_valid),
        .i_row_done (w_row_done),
        .o_idle     (w_idle),
        .o_addr_a   (w_addr_a),
        .o_addr_b   (w_addr_b),
        .o_issue    (w_issue)
    );

    polymul_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (w_issue),
        .i_coef_a    (w_coef_a),
        .i_coef_b    (w_coef_b),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_row_done  (w_row_done)
    );

endmodule

### rtl/polymul_checker.sv
// port-level checker for the polynomial multiplier, bound to the top level
module polymul_checker import polymul_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input t_in_item           i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input t_out_item          o_out_data,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [PADDR_W-1:0] paddr,
    input logic [31:0]        pwdata,
    input logic [31:0]        prdata,
    input logic               pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output transfer dropped or changed while stalled");

    a_busy_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last |-> !o_in_ready)
        else $error("input accepted in the middle of a product");

    a_start_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.req_type == REQ_START |=> !o_in_ready)
        else $error("input still ready after a start transfer");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> int'(o_out_data.product_index) <= 2 * MAX_DEGREE)
        else $error("product index beyond the highest degree");

endmodule

bind polynomial_multiplier polymul_checker u_checker (.*);

### test/tb_polynomial_multiplier.sv
// testbench of the polynomial multiplier: random load and multiply traffic checked against a convolution predictor
module tb_polynomial_multiplier;
    import polymul_pkg::*;

    localparam logic [1:0]         REQ_UNUSED = 2'd3;
    localparam logic [PADDR_W-1:0] ADDR_DEG_A = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_DEG_B = 3'd4;
    localparam int                 SETTLE     = 16;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    t_in_item           i_in_data  = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    t_out_item          o_out_data;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;

    polynomial_multiplier u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    t_in_item         coef_feed[$];
    t_out_item        expected_products[$];
    logic [31:0]      shadow_first[RAM_DEPTH];
    logic [31:0]      shadow_second[RAM_DEPTH];
    logic [DEG_W-1:0] cfg_deg_a = '0;
    logic [DEG_W-1:0] cfg_deg_b = '0;
    bit               loaded_first[RAM_DEPTH];
    bit               loaded_second[RAM_DEPTH];
    int               mismatch_count = 0;
    bit               in_fire  = 1'b0;
    bit               out_fire = 1'b0;
    bit               feed_busy = 1'b0;
    int               feed_gap = 0;
    int               feed_burst = 0;
    int               sink_stall = 0;
    int               sink_burst = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #16_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic note_mismatch(input string what);
        mismatch_count++;
        $display("error %0d at %0t: %s", mismatch_count, $realtime, what);
    endtask

    function automatic int draw_gap(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    // for one accepted transfer: update the shadow stores on a load, or queue their convolution on a start
    task automatic predict_products(input t_in_item it);
        logic [DEG_W-1:0] da;
        logic [DEG_W-1:0] db;
        int               top;
        int               lo;
        int               hi;
        logic [31:0]      acc;
        t_out_item        res;
        da = (int'(cfg_deg_a) > MAX_DEGREE) ? DEG_W'(MAX_DEGREE) : cfg_deg_a;
        db = (int'(cfg_deg_b) > MAX_DEGREE) ? DEG_W'(MAX_DEGREE) : cfg_deg_b;
        case (it.req_type)
            REQ_LOAD_A: shadow_first[it.coef_index] = it.coef_value;
            REQ_LOAD_B: shadow_second[it.coef_index] = it.coef_value;
            REQ_START: begin
                top = int'(da) + int'(db);
                for (int k = 0; k <= top; k++) begin
                    lo = (k > int'(db)) ? k - int'(db) : 0;
                    hi = (k < int'(da)) ? k : int'(da);
                    acc = '0;
                    for (int i = lo; i <= hi; i++) begin
                        acc = acc + shadow_first[i] * shadow_second[k - i];
                    end
                    res.product_index = IDX_W'(k);
                    res.product_coef  = acc;
                    res.last          = (k == top);
                    expected_products.push_back(res);
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        in_fire  = i_rst_n && i_in_valid && o_in_ready;
        out_fire = i_rst_n && o_out_valid && i_out_ready;
        if (out_fire) begin
            if (expected_products.size() == 0) begin
                note_mismatch($sformatf("unexpected product transfer index %0d",
                                        o_out_data.product_index));
            end else begin
                want = expected_products.pop_front();
                if (o_out_data.product_index !== want.product_index) begin
                    note_mismatch($sformatf("product_index got %0d want %0d",
                                            o_out_data.product_index, want.product_index));
                end
                if (o_out_data.product_coef !== want.product_coef) begin
                    note_mismatch($sformatf("product_coef[%0d] got %h want %h",
                                            want.product_index, o_out_data.product_coef,
                                            want.product_coef));
                end
                if (o_out_data.last !== want.last) begin
                    note_mismatch($sformatf("last[%0d] got %b want %b",
                                            want.product_index, o_out_data.last, want.last));
                end
            end
        end
        if (in_fire) begin
            predict_products(i_in_data);
        end
    end

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (feed_busy && in_fire) begin
                feed_busy = 1'b0;
                feed_gap  = draw_gap(feed_burst);
            end
            if (!feed_busy) begin
                if (feed_gap > 0) begin
                    feed_gap--;
                end else if (coef_feed.size() > 0) begin
                    i_in_data <= coef_feed.pop_front();
                    feed_busy = 1'b1;
                end
            end
            i_in_valid <= feed_busy;
        end
    end

    // output back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (out_fire) begin
                sink_stall = draw_gap(sink_burst);
            end
            if (sink_stall > 0) begin
                sink_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == ADDR_DEG_A) begin
            cfg_deg_a = data[DEG_W-1:0];
        end else begin
            cfg_deg_b = data[DEG_W-1:0];
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic cfg_check(input logic [PADDR_W-1:0] addr, input logic [DEG_W-1:0] want);
        logic [31:0] got;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        got = prdata;
        if (got[DEG_W-1:0] !== want) begin
            note_mismatch($sformatf("register at %0d read %0d want %0d",
                                    addr, got[DEG_W-1:0], want));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // junk in the upper pwdata bits must be dropped
    task automatic set_degrees(input logic [DEG_W-1:0] da, input logic [DEG_W-1:0] db);
        cfg_write(ADDR_DEG_A, ($urandom() & ~32'h1f) | 32'(da));
        cfg_write(ADDR_DEG_B, ($urandom() & ~32'h1f) | 32'(db));
        cfg_check(ADDR_DEG_A, da);
        cfg_check(ADDR_DEG_B, db);
    endtask

    task automatic wait_idle();
        while (coef_feed.size() != 0 || feed_busy || expected_products.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'($urandom_range(0, 1));
            default: return $urandom();
        endcase
    endfunction

    task automatic push_item(input logic [1:0] req, input int idx, input logic [31:0] val);
        t_in_item it;
        it.req_type   = req;
        it.coef_index = DEG_W'(idx);
        it.coef_value = val;
        if (req == REQ_LOAD_A) loaded_first[idx] = 1'b1;
        if (req == REQ_LOAD_B) loaded_second[idx] = 1'b1;
        coef_feed.push_back(it);
    endtask

    // fill any entry the multiply will read that has never been loaded, then queue a start transfer
    task automatic push_start();
        for (int i = 0; i <= int'(cfg_deg_a); i++) begin
            if (!loaded_first[i]) push_item(REQ_LOAD_A, i, pick_value());
        end
        for (int i = 0; i <= int'(cfg_deg_b); i++) begin
            if (!loaded_second[i]) push_item(REQ_LOAD_B, i, pick_value());
        end
        push_item(REQ_START, $urandom_range(0, MAX_DEGREE), $urandom());
    endtask

    function automatic int pick_index(input logic [DEG_W-1:0] deg);
        if ($urandom_range(0, 9) < 7) return $urandom_range(0, int'(deg));
        return $urandom_range(0, MAX_DEGREE);
    endfunction

    task automatic random_phase(input int n);
        int r;
        for (int j = 0; j < n; j++) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                for (int i = 0; i <= int'(cfg_deg_a); i++) push_item(REQ_LOAD_A, i, pick_value());
                for (int i = 0; i <= int'(cfg_deg_b); i++) push_item(REQ_LOAD_B, i, pick_value());
                push_start();
            end else if (r < 42) begin
                push_item(REQ_LOAD_A, pick_index(cfg_deg_a), pick_value());
            end else if (r < 78) begin
                push_item(REQ_LOAD_B, pick_index(cfg_deg_b), pick_value());
            end else if (r < 94) begin
                push_start();
            end else begin
                push_item(REQ_UNUSED, $urandom_range(0, MAX_DEGREE), $urandom());
            end
        end
        push_start();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        cfg_check(ADDR_DEG_A, '0);
        cfg_check(ADDR_DEG_B, '0);

        // constant polynomials, extreme values and wrap-around
        push_item(REQ_UNUSED, 0, 32'h0);
        push_item(REQ_LOAD_A, 0, 32'h7fff_ffff);
        push_item(REQ_LOAD_B, 0, 32'h7fff_ffff);
        push_start();
        push_item(REQ_LOAD_A, 0, 32'h8000_0000);
        push_item(REQ_LOAD_B, 0, 32'h8000_0000);
        push_start();
        push_item(REQ_LOAD_A, 0, 32'hffff_ffff);
        push_item(REQ_LOAD_B, 0, 32'h0000_0001);
        push_item(REQ_LOAD_A, MAX_DEGREE, 32'hffff_ffff);
        push_item(REQ_LOAD_B, MAX_DEGREE, 32'h8000_0000);
        push_item(REQ_UNUSED, MAX_DEGREE, 32'hffff_ffff);
        push_start();
        wait_idle();

        set_degrees(5'd1, 5'd2);
        push_item(REQ_LOAD_A, 0, 32'h8000_0000);
        push_item(REQ_LOAD_A, 1, 32'hffff_ffff);
        push_item(REQ_LOAD_B, 0, 32'h7fff_ffff);
        push_item(REQ_LOAD_B, 1, 32'h0000_0000);
        push_item(REQ_LOAD_B, 2, 32'h8000_0001);
        push_start();
        push_item(REQ_LOAD_B, 1, 32'h0000_0003);
        push_start();
        wait_idle();

        set_degrees(5'd31, 5'd31);
        random_phase(14);
        wait_idle();
        set_degrees(5'd31, 5'd0);
        random_phase(14);
        wait_idle();
        set_degrees(5'd0, 5'd31);
        random_phase(14);
        wait_idle();
        for (int p = 0; p < 9; p++) begin
            if (p == 4) begin
                set_degrees(DEG_W'($urandom_range(0, MAX_DEGREE)),
                            DEG_W'($urandom_range(0, MAX_DEGREE)));
            end else begin
                set_degrees(DEG_W'($urandom_range(0, 6)), DEG_W'($urandom_range(0, 6)));
            end
            random_phase(14);
            wait_idle();
        end
        set_degrees(5'd0, 5'd0);
        random_phase(10);
        wait_idle();

        repeat (50) @(posedge i_clk);
        if (expected_products.size() != 0) begin
            note_mismatch($sformatf("%0d products never arrived", expected_products.size()));
        end
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
